@@ rtl/gcs_pkg.sv @@
`default_nettype none
// ============================================================================
// gcs_pkg: shared types and constants for the genotype call statistics block
// Holds the command codes, the allele base codes, the counter layout and the
// per-call increment record passed between the classifier and the counters.
// ============================================================================
package gcs_pkg;

    localparam int CHROM_BITS  = 5;
    localparam int ALLELE_BITS = 8;
    localparam int FIELD_BITS  = 32;

    // Chromosome numbers with a meaning of their own.
    localparam logic [CHROM_BITS-1:0] CHROM_X    = 5'd23;
    localparam logic [CHROM_BITS-1:0] CHROM_Y    = 5'd24;
    localparam logic [CHROM_BITS-1:0] CHROM_MITO = 5'd25;

    // ASCII codes of the proper bases.
    localparam logic [ALLELE_BITS-1:0] CHAR_A = 8'h41;
    localparam logic [ALLELE_BITS-1:0] CHAR_C = 8'h43;
    localparam logic [ALLELE_BITS-1:0] CHAR_G = 8'h47;
    localparam logic [ALLELE_BITS-1:0] CHAR_T = 8'h54;

    typedef enum logic
    {
        CMD_COUNT = 1'b0,
        CMD_READ  = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        BASE_A,
        BASE_C,
        BASE_G,
        BASE_T,
        BASE_NONE
    } base_t;

    // Order of the six counters kept per chromosome and genome wide.
    localparam int CNT_CALL  = 0;
    localparam int CNT_HOMO  = 1;
    localparam int CNT_BASE0 = 2;
    localparam int NUM_BASES = 4;
    localparam int NUM_CNT   = 6;

    typedef logic [1:0] amount_t;

    typedef struct packed
    {
        logic [NUM_CNT-1:0][1:0] amount;
        logic                    autosomal;
        logic                    double_x;
        logic                    set_y;
        logic                    set_mito;
    } incr_t;

    function automatic base_t base_code(input logic [ALLELE_BITS-1:0] ch);
        base_t code;
        case (ch)
            CHAR_A:  code = BASE_A;
            CHAR_C:  code = BASE_C;
            CHAR_G:  code = BASE_G;
            CHAR_T:  code = BASE_T;
            default: code = BASE_NONE;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

@@ rtl/gcs_if.sv @@
`default_nettype none
// ============================================================================
// gcs_if: stream interfaces of the genotype call statistics block
// gcs_call_if carries call and read commands in; gcs_stats_if carries the
// counter snapshots out. Both use a valid/ready handshake.
// ============================================================================
interface gcs_call_if;
    logic                               valid;
    logic                               ready;
    logic                               command;
    logic [gcs_pkg::CHROM_BITS-1:0]     chromosome;
    logic [gcs_pkg::ALLELE_BITS-1:0]    allele_first;
    logic [gcs_pkg::ALLELE_BITS-1:0]    allele_second;
    logic                               read_whole_genome;

    modport source
    (
        output valid, command, chromosome, allele_first, allele_second,
               read_whole_genome,
        input  ready
    );

    modport sink
    (
        input  valid, command, chromosome, allele_first, allele_second,
               read_whole_genome,
        output ready
    );
endinterface

interface gcs_stats_if;
    logic                               valid;
    logic                               ready;
    logic [gcs_pkg::FIELD_BITS-1:0]     call_total;
    logic [gcs_pkg::FIELD_BITS-1:0]     homozygous_total;
    logic [gcs_pkg::FIELD_BITS-1:0]     adenine_total;
    logic [gcs_pkg::FIELD_BITS-1:0]     cytosine_total;
    logic [gcs_pkg::FIELD_BITS-1:0]     guanine_total;
    logic [gcs_pkg::FIELD_BITS-1:0]     thymine_total;
    logic [gcs_pkg::FIELD_BITS-1:0]     autosomal_total;
    logic [gcs_pkg::FIELD_BITS-1:0]     double_x_total;
    logic                               seen_y;
    logic                               seen_mito;

    modport source
    (
        output valid, call_total, homozygous_total, adenine_total, cytosine_total,
               guanine_total, thymine_total, autosomal_total, double_x_total,
               seen_y, seen_mito,
        input  ready
    );

    modport sink
    (
        input  valid, call_total, homozygous_total, adenine_total, cytosine_total,
               guanine_total, thymine_total, autosomal_total, double_x_total,
               seen_y, seen_mito,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/gcs_classify.sv @@
`default_nettype none
// ============================================================================
// gcs_classify: call classifier
// Decodes the two allele characters and the chromosome of one call into the
// amounts added to each counter and the genome-wide side effects.
// ============================================================================
module gcs_classify
(
    input  wire logic [gcs_pkg::CHROM_BITS-1:0]  chromosome,
    input  wire logic [gcs_pkg::ALLELE_BITS-1:0] allele_first,
    input  wire logic [gcs_pkg::ALLELE_BITS-1:0] allele_second,
    output gcs_pkg::incr_t                       incr
);

    gcs_pkg::base_t code_first;
    gcs_pkg::base_t code_second;
    logic           proper_first;
    logic           proper_second;
    logic           any_proper;
    logic           homozygous;

    assign code_first    = gcs_pkg::base_code(allele_first);
    assign code_second   = gcs_pkg::base_code(allele_second);
    assign proper_first  = (code_first != gcs_pkg::BASE_NONE);
    assign proper_second = (code_second != gcs_pkg::BASE_NONE);
    assign any_proper    = proper_first || proper_second;
    assign homozygous    = any_proper && (allele_first == allele_second);

    always_comb
    begin
        incr = '0;
        incr.amount[gcs_pkg::CNT_CALL] = 2'd1;
        incr.amount[gcs_pkg::CNT_HOMO] = {1'b0, homozygous};
        // A homozygous call adds two to its base; otherwise each proper
        // character adds one.
        for (int b = 0; b < gcs_pkg::NUM_BASES; b++)
        begin
            if (homozygous)
            begin
                incr.amount[gcs_pkg::CNT_BASE0 + b] =
                    (code_first == gcs_pkg::base_t'(b)) ? 2'd2 : 2'd0;
            end
            else
            begin
                incr.amount[gcs_pkg::CNT_BASE0 + b] =
                    {1'b0, code_first == gcs_pkg::base_t'(b)}
                    + {1'b0, code_second == gcs_pkg::base_t'(b)};
            end
        end
        incr.autosomal = (chromosome < gcs_pkg::CHROM_X);
        incr.double_x  = (chromosome == gcs_pkg::CHROM_X) && proper_first && proper_second;
        incr.set_y     = (chromosome == gcs_pkg::CHROM_Y) && any_proper;
        incr.set_mito  = (chromosome == gcs_pkg::CHROM_MITO) && any_proper;
    end

endmodule
`default_nettype wire

@@ rtl/gcs_chrom_bank.sv @@
`default_nettype none
// ============================================================================
// gcs_chrom_bank: per-chromosome counter bank
// Six saturating counters for each chromosome slot, read at one slot and
// updated in place in the same cycle. Slots beyond the bank read as zero.
// ============================================================================
module gcs_chrom_bank
#(
    parameter int SLOTS    = 26,
    parameter int CNT_BITS = 32
)
(
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         upd_en,
    input  wire logic [gcs_pkg::CHROM_BITS-1:0]               chromosome,
    input  wire gcs_pkg::incr_t                               incr,
    output logic [gcs_pkg::NUM_CNT-1:0][CNT_BITS-1:0]         rd_count
);

    localparam int IDX_W = $clog2(SLOTS);

    logic [gcs_pkg::NUM_CNT-1:0][CNT_BITS-1:0] count_reg [SLOTS];
    logic [gcs_pkg::NUM_CNT-1:0][CNT_BITS-1:0] row_next;
    logic                                      in_slots;
    logic [IDX_W-1:0]                          idx;

    function automatic logic [CNT_BITS-1:0] sat_add(input logic [CNT_BITS-1:0] value,
                                                    input gcs_pkg::amount_t amount);
        logic [CNT_BITS:0] sum;
        sum = {1'b0, value} + (CNT_BITS+1)'(amount);
        return sum[CNT_BITS] ? {CNT_BITS{1'b1}} : sum[CNT_BITS-1:0];
    endfunction

    assign in_slots = ({1'b0, chromosome} < (gcs_pkg::CHROM_BITS+1)'(SLOTS));
    assign idx      = chromosome[IDX_W-1:0];
    assign rd_count = in_slots ? count_reg[idx] : '0;

    always_comb
    begin
        for (int k = 0; k < gcs_pkg::NUM_CNT; k++)
        begin
            row_next[k] = sat_add(rd_count[k], incr.amount[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                count_reg[s] <= '0;
            end
        end
        else if (upd_en && in_slots)
        begin
            count_reg[idx] <= row_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/genotype_call_statistics_top.sv @@
`default_nettype none
// ============================================================================
// genotype_call_statistics_top: variant call statistics accumulator
// Counts calls, homozygous calls and A/C/G/T alleles per chromosome and
// genome wide, and answers read commands with a snapshot of the counters.
// ============================================================================
//
// Usage:
//   calls  - input channel. Each transaction is either a count command (one
//            call: chromosome plus two allele characters) or a read command
//            (read_whole_genome selects genome totals or one chromosome).
//   stats  - output channel. Every input transaction yields exactly one output
//            transaction: a count returns the genome totals after the update,
//            a read returns the selected counters. The autosomal and double-X
//            totals and the Y and mitochondrial flags are always genome wide.
//   The transaction lands in an input register; the counters are then read,
//   updated and written back while the result register loads, and the result
//   is shown from that register.
//   Throughput is one transaction per cycle while the receiver does not stall;
//   the counter bank is read, updated and written back in place, which removes
//   any hazard between back-to-back calls on the same chromosome.
//   Reset clears every counter and flag at once; no sweep is needed.
//   When the receiver stalls, the result register and the input register hold,
//   and if the input register is full, calls.ready drops until stats.ready returns.
//   All counters saturate at their maximum and are shown in 32-bit fields.
// ============================================================================
module genotype_call_statistics_top
#(
    parameter int CHROMOSOME_SLOTS = 26,
    parameter int COUNTER_BITS     = 32
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    gcs_call_if.sink  calls,
    gcs_stats_if.source stats
);

    localparam int FW = gcs_pkg::FIELD_BITS;

    // Input register stage.
    logic                               s1_valid_reg;
    gcs_pkg::cmd_t                      s1_cmd_reg;
    logic [gcs_pkg::CHROM_BITS-1:0]     s1_chrom_reg;
    logic [gcs_pkg::ALLELE_BITS-1:0]    s1_first_reg;
    logic [gcs_pkg::ALLELE_BITS-1:0]    s1_second_reg;
    logic                               s1_whole_reg;

    // Genome-wide state.
    logic [gcs_pkg::NUM_CNT-1:0][COUNTER_BITS-1:0] genome_reg;
    logic [gcs_pkg::NUM_CNT-1:0][COUNTER_BITS-1:0] genome_next;
    logic [COUNTER_BITS-1:0]            autosomal_reg;
    logic [COUNTER_BITS-1:0]            autosomal_next;
    logic [COUNTER_BITS-1:0]            double_x_reg;
    logic [COUNTER_BITS-1:0]            double_x_next;
    logic                               seen_y_reg;
    logic                               seen_y_next;
    logic                               seen_mito_reg;
    logic                               seen_mito_next;

    // Result register.
    logic                               res_valid_reg;
    logic [gcs_pkg::NUM_CNT-1:0][FW-1:0] res_count_reg;
    logic [gcs_pkg::NUM_CNT-1:0][FW-1:0] res_count_next;
    logic [FW-1:0]                      res_auto_reg;
    logic [FW-1:0]                      res_xx_reg;
    logic                               res_y_reg;
    logic                               res_mito_reg;

    logic                               accept;
    logic                               advance;
    logic                               count_en;
    gcs_pkg::incr_t                     incr;
    logic [gcs_pkg::NUM_CNT-1:0][COUNTER_BITS-1:0] chrom_count;

    function automatic logic [COUNTER_BITS-1:0] sat_add(input logic [COUNTER_BITS-1:0] value,
                                                        input gcs_pkg::amount_t amount);
        logic [COUNTER_BITS:0] sum;
        sum = {1'b0, value} + (COUNTER_BITS+1)'(amount);
        return sum[COUNTER_BITS] ? {COUNTER_BITS{1'b1}} : sum[COUNTER_BITS-1:0];
    endfunction

    // The work stage moves on whenever the result register is free or being
    // emptied this cycle.
    assign advance     = s1_valid_reg && (!res_valid_reg || stats.ready);
    assign calls.ready = !s1_valid_reg || !res_valid_reg || stats.ready;
    assign accept      = calls.valid && calls.ready;
    assign count_en    = advance && (s1_cmd_reg == gcs_pkg::CMD_COUNT);

    gcs_classify u_classify
    (
        .chromosome    (s1_chrom_reg),
        .allele_first  (s1_first_reg),
        .allele_second (s1_second_reg),
        .incr          (incr)
    );

    gcs_chrom_bank
    #(
        .SLOTS    (CHROMOSOME_SLOTS),
        .CNT_BITS (COUNTER_BITS)
    )
    u_chrom_bank
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd_en     (count_en),
        .chromosome (s1_chrom_reg),
        .incr       (incr),
        .rd_count   (chrom_count)
    );

    // Genome-wide next state. With no count in progress every next value
    // equals the current one, so reads see the same numbers.
    always_comb
    begin
        for (int k = 0; k < gcs_pkg::NUM_CNT; k++)
        begin
            genome_next[k] = count_en ? sat_add(genome_reg[k], incr.amount[k])
                                      : genome_reg[k];
        end
        autosomal_next = (count_en && incr.autosomal)
                         ? sat_add(autosomal_reg, 2'd1) : autosomal_reg;
        double_x_next  = (count_en && incr.double_x)
                         ? sat_add(double_x_reg, 2'd1) : double_x_reg;
        seen_y_next    = seen_y_reg || (count_en && incr.set_y);
        seen_mito_next = seen_mito_reg || (count_en && incr.set_mito);
    end

    // A chromosome read shows the bank; everything else shows genome totals.
    always_comb
    begin
        for (int k = 0; k < gcs_pkg::NUM_CNT; k++)
        begin
            if (s1_cmd_reg == gcs_pkg::CMD_READ && !s1_whole_reg)
            begin
                res_count_next[k] = FW'(chrom_count[k]);
            end
            else
            begin
                res_count_next[k] = FW'(genome_next[k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg    <= gcs_pkg::cmd_t'(calls.command);
            s1_chrom_reg  <= calls.chromosome;
            s1_first_reg  <= calls.allele_first;
            s1_second_reg <= calls.allele_second;
            s1_whole_reg  <= calls.read_whole_genome;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            genome_reg    <= '0;
            autosomal_reg <= '0;
            double_x_reg  <= '0;
            seen_y_reg    <= 1'b0;
            seen_mito_reg <= 1'b0;
        end
        else
        begin
            genome_reg    <= genome_next;
            autosomal_reg <= autosomal_next;
            double_x_reg  <= double_x_next;
            seen_y_reg    <= seen_y_next;
            seen_mito_reg <= seen_mito_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (stats.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_count_reg <= res_count_next;
            res_auto_reg  <= FW'(autosomal_next);
            res_xx_reg    <= FW'(double_x_next);
            res_y_reg     <= seen_y_next;
            res_mito_reg  <= seen_mito_next;
        end
    end

    assign stats.valid            = res_valid_reg;
    assign stats.call_total       = res_count_reg[gcs_pkg::CNT_CALL];
    assign stats.homozygous_total = res_count_reg[gcs_pkg::CNT_HOMO];
    assign stats.adenine_total    = res_count_reg[gcs_pkg::CNT_BASE0];
    assign stats.cytosine_total   = res_count_reg[gcs_pkg::CNT_BASE0 + 1];
    assign stats.guanine_total    = res_count_reg[gcs_pkg::CNT_BASE0 + 2];
    assign stats.thymine_total    = res_count_reg[gcs_pkg::CNT_BASE0 + 3];
    assign stats.autosomal_total  = res_auto_reg;
    assign stats.double_x_total   = res_xx_reg;
    assign stats.seen_y           = res_y_reg;
    assign stats.seen_mito        = res_mito_reg;

    // Input is refused only while both stages hold work and the output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        !calls.ready |-> (s1_valid_reg && res_valid_reg && !stats.ready))
        else $error("calls.ready low without a full, stalled pipeline");

    // Once a sticky flag is set, the two flags are never both clear again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (seen_y_reg || seen_mito_reg) |=> (seen_y_reg || seen_mito_reg))
        else $error("sticky chromosome flag cleared");

    // A counted call always leaves a nonzero genome call total.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_en |=> (genome_reg[gcs_pkg::CNT_CALL] != '0))
        else $error("genome call total zero after a count");

    // Autosomal calls are a subset of all calls.
    assert property (@(posedge clk) disable iff (!rst_n)
        autosomal_reg <= genome_reg[gcs_pkg::CNT_CALL])
        else $error("autosomal total exceeds call total");

    // A result is loaded exactly when the work stage moves on.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("work stage advanced without loading a result");

endmodule
`default_nettype wire
